>>> rtl/core/bwc_pkg.sv
// shared types, constants and divider step for the wavetable crossfade oscillator
`default_nettype none
package bwc_pkg;

  localparam int FRAC_W     = 24;
  localparam int POS_W      = 8;
  localparam int TABLE_LEN  = 256;
  localparam int SAMPLE_W   = 16;
  localparam int FQ_W       = 16;
  localparam int FREM_W     = 23;
  localparam int BQ_W       = 7;
  localparam int DIV_STAGES = 8;

  localparam logic [31:0] BAND_DIVIDEND  = 32'h8000_0000;
  localparam logic [31:0] BIG_FREQ_LIMIT = 32'h0100_0000;
  localparam logic [16:0] F_UNITY        = 17'h10000;

  localparam logic [1:0] CFG_RANGE_START = 2'd0;
  localparam logic [1:0] CFG_RANGE_END   = 2'd1;
  localparam logic [1:0] CFG_ACTIVE      = 2'd2;

  typedef enum logic [1:0] {FM_ZERO, FM_FULL, FM_DIV} fmode_t;
  typedef enum logic {ACT_WRITE = 1'b0, ACT_COMPUTE = 1'b1} action_t;

  // one item travelling through the quotient stages
  typedef struct packed {
    logic                valid;
    logic                compute;
    logic                wr_ok;
    logic                tsel;
    logic [6:0]          wband;
    logic [POS_W-1:0]    wpos;
    logic [SAMPLE_W-1:0] wval;
    logic [POS_W-1:0]    pos;
    logic [FRAC_W-1:0]   frac;
    logic [15:0]         amp;
    fmode_t              fmode;
    logic [FREM_W-1:0]   frem;
    logic [FQ_W-1:0]     fq;
    logic                freq_small;
    logic [31:0]         freq;
    logic [31:0]         brem;
    logic [BQ_W-1:0]     bq;
  } div_item_t;

  // stage k: one band quotient bit (for k below BQ_W) and two crossfade quotient bits
  function automatic div_item_t div_step(input div_item_t it, input int k,
                                         input logic [7:0] fd);
    div_item_t   o;
    logic [38:0] bt;
    logic [23:0] ft;
    int          fb;
    o = it;
    if (k < BQ_W) begin
      bt = {7'd0, it.freq} << (BQ_W - 1 - k);
      if ({7'd0, it.brem} >= bt) begin
        o.brem = it.brem - bt[31:0];
        o.bq[BQ_W-1-k] = 1'b1;
      end
    end
    for (int j = 0; j < 2; j++) begin
      fb = FQ_W - 1 - 2 * k - j;
      ft = {16'd0, fd} << fb;
      if ({1'b0, o.frem} >= ft) begin
        o.frem = o.frem - ft[FREM_W-1:0];
        o.fq[fb] = 1'b1;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bwc_table_ram.sv
// single-port wave table memory with registered read data
`default_nettype none
module bwc_table_ram #(
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [15:0]              wdata,
  output logic      [15:0]              rdata
);

  logic [15:0] mem [DEPTH];

  // write wins the port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bandlimited_wavetable_crossfade.sv
// top level of the band-limited two-table wavetable oscillator with crossfade
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+------------------------
//  in      | in_valid/in_ready + fields     | in_valid & in_ready
//  out     | out_valid/out_ready + audio    | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// items are not taken back to back: each table is a single-port memory read
// twice per compute item (sample and neighbour), and writes use the same port.
// reset is synchronous; tables are not cleared. a held output stalls the pipe.
`default_nettype none
module bandlimited_wavetable_crossfade #(
  parameter int BAND_COUNT = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [31:0]        in_phase,
  input  wire logic [31:0]        in_freq_word,
  input  wire logic [15:0]        in_amplitude,
  input  wire logic [13:0]        in_timbre_index,
  input  wire logic               in_table_select,
  input  wire logic [6:0]         in_band_number,
  input  wire logic [7:0]         in_table_position,
  input  wire logic signed [15:0] in_sample_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_audio_out
);
  import bwc_pkg::*;

  localparam int BAND_W = $clog2(BAND_COUNT);
  localparam int ADDR_W = BAND_W + POS_W;
  localparam int DEPTH  = BAND_COUNT * TABLE_LEN;
  localparam logic [7:0] LAST_BAND  = 8'(BAND_COUNT - 1);
  localparam logic [7:0] BAND_LIMIT = 8'(BAND_COUNT);

  // configuration registers
  logic [6:0] range_start_r;
  logic [7:0] range_end_r;
  logic       active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= 7'd0;
      range_end_r   <= 8'd128;
      active_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_START: range_start_r <= cfg_wdata[6:0];
        CFG_RANGE_END:   range_end_r   <= cfg_wdata;
        CFG_ACTIVE:      active_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic in_fire;
  logic out_valid_r;
  logic signed [31:0] out_audio_r;

  div_item_t pipe_r   [DIV_STAGES+1];
  div_item_t pipe_nxt [DIV_STAGES];
  div_item_t pipe0_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !pipe_r[0].valid;
  assign in_fire  = in_valid && in_ready;

  // crossfade numerator, divisor and mode at entry
  logic signed [14:0] num;
  logic [7:0]         fdiv;
  fmode_t             fmode;

  assign num  = $signed({1'b0, in_timbre_index}) - $signed({1'b0, range_start_r, 7'd0});
  assign fdiv = range_end_r - {1'b0, range_start_r};

  always_comb begin
    if (range_end_r <= {1'b0, range_start_r}) begin
      fmode = num[14] ? FM_ZERO : FM_FULL;
    end else if (num[14] || num == 15'sd0) begin
      fmode = FM_ZERO;
    end else if ({1'b0, num[13:0]} >= {fdiv, 7'd0}) begin
      fmode = FM_FULL;
    end else begin
      fmode = FM_DIV;
    end
  end

  always_comb begin
    pipe0_nxt            = '0;
    pipe0_nxt.valid      = in_fire;
    pipe0_nxt.compute    = (in_action == ACT_COMPUTE);
    pipe0_nxt.wr_ok      = ({1'b0, in_band_number} < BAND_LIMIT);
    pipe0_nxt.tsel       = in_table_select;
    pipe0_nxt.wband      = in_band_number;
    pipe0_nxt.wpos       = in_table_position;
    pipe0_nxt.wval       = in_sample_value;
    pipe0_nxt.pos        = in_phase[31:24];
    pipe0_nxt.frac       = in_phase[FRAC_W-1:0];
    pipe0_nxt.amp        = in_amplitude;
    pipe0_nxt.fmode      = fmode;
    pipe0_nxt.frem       = {num[13:0], 9'd0};
    pipe0_nxt.freq_small = (in_freq_word <= BIG_FREQ_LIMIT);
    pipe0_nxt.freq       = in_freq_word;
    pipe0_nxt.brem       = BAND_DIVIDEND;
  end

  // quotient stages for band and crossfade fraction
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      pipe_nxt[k] = div_step(pipe_r[k], k, fdiv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        pipe_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      pipe_r[0] <= pipe0_nxt;
      for (int k = 0; k < DIV_STAGES; k++) begin
        pipe_r[k+1] <= pipe_nxt[k];
      end
    end
  end

  // first memory access: band select, write or first sample read
  div_item_t        a_it;
  logic [7:0]       qm1;
  logic [7:0]       band_full;
  logic [BAND_W-1:0] band_a;
  logic [16:0]      f_a;

  assign a_it = pipe_r[DIV_STAGES];

  always_comb begin
    qm1 = {1'b0, a_it.bq} - 8'd1;
    if (a_it.freq_small) begin
      band_full = LAST_BAND;
    end else if (a_it.bq == '0) begin
      band_full = 8'd0;
    end else begin
      band_full = (qm1 > LAST_BAND) ? LAST_BAND : qm1;
    end
  end
  assign band_a = band_full[BAND_W-1:0];

  always_comb begin
    case (a_it.fmode)
      FM_ZERO: f_a = 17'd0;
      FM_FULL: f_a = F_UNITY;
      FM_DIV:  f_a = {1'b0, a_it.fq};
      default: f_a = 17'd0;
    endcase
  end

  logic              m2_valid_r;
  logic [ADDR_W-1:0] m2_addr_r;
  logic [FRAC_W-1:0] m2_frac_r;
  logic [15:0]       m2_amp_r;
  logic [16:0]       m2_f_r;

  // port sharing: items never enter back to back, so the two stages never collide
  logic              mem_read, we0, we1;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       rdata0, rdata1;

  always_comb begin
    if (m2_valid_r) begin
      mem_addr = m2_addr_r;
    end else if (a_it.compute) begin
      mem_addr = {band_a, a_it.pos};
    end else begin
      mem_addr = {a_it.wband[BAND_W-1:0], a_it.wpos};
    end
    mem_read = adv && (m2_valid_r || (a_it.valid && a_it.compute));
    we0 = adv && a_it.valid && !a_it.compute && a_it.wr_ok && !a_it.tsel;
    we1 = adv && a_it.valid && !a_it.compute && a_it.wr_ok && a_it.tsel;
  end

  bwc_table_ram #(.DEPTH(DEPTH)) u_first_table (
    .clk   (clk),
    .rd_en (mem_read),
    .we    (we0),
    .addr  (mem_addr),
    .wdata (a_it.wval),
    .rdata (rdata0)
  );

  bwc_table_ram #(.DEPTH(DEPTH)) u_second_table (
    .clk   (clk),
    .rd_en (mem_read),
    .we    (we1),
    .addr  (mem_addr),
    .wdata (a_it.wval),
    .rdata (rdata1)
  );

  // second read at the neighbour, wrapping inside the band
  logic              m3_valid_r;
  logic signed [15:0] m3_a0_r, m3_a1_r;
  logic [FRAC_W-1:0] m3_frac_r;
  logic [15:0]       m3_amp_r;
  logic [16:0]       m3_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
    end else if (adv) begin
      m2_valid_r <= a_it.valid && a_it.compute;
      m3_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_addr_r <= {band_a, a_it.pos + 8'd1};
      m2_frac_r <= a_it.frac;
      m2_amp_r  <= a_it.amp;
      m2_f_r    <= f_a;
      m3_a0_r   <= rdata0;
      m3_a1_r   <= rdata1;
      m3_frac_r <= m2_frac_r;
      m3_amp_r  <= m2_amp_r;
      m3_f_r    <= m2_f_r;
    end
  end

  // interpolation slope times fraction, one multiplier per table
  logic signed [16:0] dlt0, dlt1;
  logic signed [41:0] prod0, prod1;

  assign dlt0  = $signed({rdata0[15], rdata0}) - $signed({m3_a0_r[15], m3_a0_r});
  assign dlt1  = $signed({rdata1[15], rdata1}) - $signed({m3_a1_r[15], m3_a1_r});
  assign prod0 = dlt0 * $signed({1'b0, m3_frac_r});
  assign prod1 = dlt1 * $signed({1'b0, m3_frac_r});

  logic               p_valid_r;
  logic signed [15:0] p_a0_r, p_a1_r;
  logic signed [41:0] p_prod0_r, p_prod1_r;
  logic [15:0]        p_amp_r;
  logic [16:0]        p_f_r;

  // interpolated samples and their difference
  logic signed [41:0] v0, v1;
  logic signed [42:0] vd;

  assign v0 = $signed({{2{p_a0_r[15]}}, p_a0_r, 24'd0}) + p_prod0_r;
  assign v1 = $signed({{2{p_a1_r[15]}}, p_a1_r, 24'd0}) + p_prod1_r;
  assign vd = $signed({v1[41], v1}) - $signed({v0[41], v0});

  logic               q_valid_r;
  logic signed [41:0] q_v0_r;
  logic signed [42:0] q_vd_r;
  logic [15:0]        q_amp_r;
  logic [16:0]        q_f_r;

  // crossfade product split into high and low partial products
  logic signed [36:0] ph;
  logic [40:0]        pl;

  assign ph = $signed(q_vd_r[42:24]) * $signed({1'b0, q_f_r});
  assign pl = q_vd_r[23:0] * q_f_r;

  logic               r_valid_r;
  logic signed [41:0] r_v0_r;
  logic signed [36:0] r_ph_r;
  logic [40:0]        r_pl_r;
  logic [15:0]        r_amp_r;

  // mixed sum, scaled down to signed Q18.16
  logic signed [63:0] mix;

  assign mix = (64'(r_v0_r) <<< 16) + (64'(r_ph_r) <<< 24) + $signed({23'd0, r_pl_r});

  logic               s_valid_r;
  logic signed [33:0] s_x_r;
  logic [15:0]        s_amp_r;

  // amplitude gain with round half up
  logic signed [50:0] gain;
  logic signed [50:0] gain_rnd;
  logic signed [19:0] res;

  assign gain     = s_x_r * $signed({1'b0, s_amp_r});
  assign gain_rnd = gain + 51'sd1073741824;
  assign res      = gain_rnd[50:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      q_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r   <= m3_valid_r;
      q_valid_r   <= p_valid_r;
      r_valid_r   <= q_valid_r;
      s_valid_r   <= r_valid_r;
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_a0_r      <= m3_a0_r;
      p_a1_r      <= m3_a1_r;
      p_prod0_r   <= prod0;
      p_prod1_r   <= prod1;
      p_amp_r     <= m3_amp_r;
      p_f_r       <= m3_f_r;
      q_v0_r      <= v0;
      q_vd_r      <= vd;
      q_amp_r     <= p_amp_r;
      q_f_r       <= p_f_r;
      r_v0_r      <= q_v0_r;
      r_ph_r      <= ph;
      r_pl_r      <= pl;
      r_amp_r     <= q_amp_r;
      s_x_r       <= mix[57:24];
      s_amp_r     <= r_amp_r;
      out_audio_r <= active_r ? 32'(res) : 32'sd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_audio_r;

  // memory port is never claimed by both access stages at once
  a_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(m2_valid_r && pipe_r[DIV_STAGES].valid))
    else $error("table port claimed by two stages");

  // an input transfer leaves a gap cycle behind it
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken in consecutive cycles");

endmodule
`default_nettype wire
